// ----- hdl/coapser_pkg.sv -----
// coap serializer package: command and status codes, encoding constants, option nibble encoder
`timescale 1ns / 1ps

package coapser_pkg;

  typedef enum logic [2:0] {
    CMD_HEADER    = 3'd0,
    CMD_TOKEN     = 3'd1,
    CMD_OPT_START = 3'd2,
    CMD_OPT_VALUE = 3'd3,
    CMD_PAYLOAD   = 3'd4,
    CMD_END       = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_SMALL   = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    REG_OUTPUT_CAPACITY   = 1'd0,
    REG_MAX_OPTION_LENGTH = 1'd1
  } reg_index_t;

  localparam logic [1:0]  HDR_VERSION     = 2'd1;
  localparam logic [15:0] NIBBLE_MAX      = 16'd12;
  localparam logic [15:0] EXT1_OFFSET     = 16'd13;
  localparam logic [15:0] EXT1_MAX        = 16'd268;
  localparam logic [15:0] EXT2_OFFSET     = 16'd269;
  localparam logic [3:0]  NIBBLE_EXT1     = 4'd13;
  localparam logic [3:0]  NIBBLE_EXT2     = 4'd14;
  localparam logic [7:0]  PAYLOAD_MARKER  = 8'hFF;
  localparam logic [15:0] CAPACITY_RESET  = 16'd1024;
  localparam logic [15:0] MAX_OPT_LEN_RST = 16'd1034;
  localparam int          RES_DEPTH       = 5;
  localparam int          RES_IDX_W       = 3;

  // nibble plus up to two extended bytes for an option delta or length
  typedef struct packed {
    logic [3:0] nib;
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
  } ext_t;

  function automatic ext_t encode_ext(input logic [15:0] v);
    ext_t        e;
    logic [15:0] r;
    begin
      r     = v - EXT2_OFFSET;
      e.nib = v[3:0];
      e.cnt = 2'd0;
      e.b0  = 8'd0;
      e.b1  = 8'd0;
      if (v <= NIBBLE_MAX) begin
        e.nib = v[3:0];
      end else if (v <= EXT1_MAX) begin
        e.nib = NIBBLE_EXT1;
        e.cnt = 2'd1;
        e.b0  = 8'(v - EXT1_OFFSET);
      end else begin
        e.nib = NIBBLE_EXT2;
        e.cnt = 2'd2;
        e.b0  = r[15:8];
        e.b1  = r[7:0];
      end
      return e;
    end
  endfunction

endpackage

// ----- hdl/coap_message_serializer.sv -----
// coap message serializer: item register, single-pass encoder, result buffer drained one beat a cycle
//   while result_stall is low; an accepted item passes the item register, then the result buffer
// throughput: one item per cycle while each item gives one result and result_stall is low;
//   a header gives 4 result bytes, an option start 1 to 5, the first payload byte 2; error and
//   ignored items give no result and pass through without waiting on the result buffer
// reset (rst, synchronous): clears message state, both stages and restores the register defaults
`timescale 1ns / 1ps

module coap_message_serializer #(
  parameter int MAX_OPTIONS = 16,
  parameter int MAX_TOKEN   = 8
) (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // item channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  command,
  input  logic [1:0]  version,
  input  logic [1:0]  msg_type,
  input  logic [3:0]  token_len,
  input  logic [7:0]  msg_code,
  input  logic [15:0] msg_id,
  input  logic [15:0] opt_number,
  input  logic [15:0] opt_length,
  input  logic [7:0]  data_byte,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  out_byte,
  output logic        is_status,
  output logic [1:0]  status,
  output logic [15:0] byte_count,
  output logic        last
);
  import coapser_pkg::*;

  localparam int OPT_W = $clog2(MAX_OPTIONS + 1);

  // configuration
  logic [15:0] output_capacity;
  logic [15:0] max_option_length;

  // message state
  logic [15:0]      prev_opt_number, prev_opt_number_next;
  logic [15:0]      written, written_next;
  logic [OPT_W-1:0] opts_seen, opts_seen_next;
  logic [3:0]       token_left, token_left_next;
  logic [15:0]      value_left, value_left_next;
  logic             payload_begun, payload_begun_next;
  logic [1:0]       err_code, err_code_next;

  // item register
  logic        a_valid;
  logic [2:0]  a_command;
  logic [1:0]  a_version;
  logic [1:0]  a_msg_type;
  logic [3:0]  a_token_len;
  logic [7:0]  a_msg_code;
  logic [15:0] a_msg_id;
  logic [15:0] a_opt_number;
  logic [15:0] a_opt_length;
  logic [7:0]  a_data_byte;

  // result buffer
  logic                 b_valid;
  logic [7:0]           b_bytes [RES_DEPTH];
  logic [RES_IDX_W-1:0] b_cnt;
  logic [RES_IDX_W-1:0] b_idx;
  logic                 b_is_status;
  logic [1:0]           b_status;
  logic [15:0]          b_count;

  // encoder results
  logic [RES_IDX_W-1:0] res_cnt;
  logic [7:0]           res_bytes [RES_DEPTH];
  logic                 res_end;
  logic [1:0]           res_status;
  logic [15:0]          res_count;

  logic item_fire, out_fire, b_last, b_free, a_move, b_load;

  assign cfg_ready = 1'b1;

  assign out_fire  = b_valid && !result_stall;
  assign b_last    = (b_idx == b_cnt - RES_IDX_W'(1));
  assign b_free    = !b_valid || (out_fire && b_last);
  assign a_move    = a_valid && ((res_cnt == '0) || b_free);
  assign b_load    = a_move && (res_cnt != '0);
  assign item_stall = a_valid && !a_move;
  assign item_fire  = item_valid && !item_stall;

  assign result_valid = b_valid;
  assign out_byte     = b_bytes[b_idx];
  assign is_status    = b_is_status;
  assign status       = b_status;
  assign byte_count   = b_count;
  assign last         = b_last;

  // single-pass encoder for the item in the item register
  always_comb begin
    ext_t        dext;
    ext_t        lext;
    logic [15:0] delta;
    logic [2:0]  ext_n;
    logic [16:0] need;
    logic [1:0]  pos;
    logic [1:0]  q;
    logic [1:0]  st;

    res_cnt    = '0;
    res_end    = 1'b0;
    res_status = ST_OK;
    res_count  = '0;
    pos        = '0;
    q          = '0;
    for (int i = 0; i < RES_DEPTH; i++) begin
      res_bytes[i] = 8'd0;
    end
    prev_opt_number_next = prev_opt_number;
    written_next         = written;
    opts_seen_next       = opts_seen;
    token_left_next      = token_left;
    value_left_next      = value_left;
    payload_begun_next   = payload_begun;
    err_code_next        = err_code;

    delta = a_opt_number - prev_opt_number;
    dext  = encode_ext(delta);
    lext  = encode_ext(a_opt_length);
    ext_n = {1'b0, dext.cnt} + {1'b0, lext.cnt};
    need  = {1'b0, written};
    st    = err_code;

    if (a_command == CMD_END) begin
      if (err_code == ST_OK &&
          (written == '0 || token_left != '0 || value_left != '0)) begin
        st = ST_INVALID;
      end
      res_cnt    = RES_IDX_W'(1);
      res_end    = 1'b1;
      res_status = st;
      res_count  = written;
      prev_opt_number_next = '0;
      written_next         = '0;
      opts_seen_next       = '0;
      token_left_next      = '0;
      value_left_next      = '0;
      payload_begun_next   = 1'b0;
      err_code_next        = ST_OK;
    end else if (err_code == ST_OK) begin
      unique case (a_command)
        CMD_HEADER: begin
          need = {1'b0, written} + 17'd4;
          if (written != '0 || a_version != HDR_VERSION ||
              int'(a_token_len) > MAX_TOKEN) begin
            err_code_next = ST_INVALID;
          end else if (need > {1'b0, output_capacity}) begin
            err_code_next = ST_SMALL;
          end else begin
            res_cnt      = RES_IDX_W'(4);
            res_bytes[0] = {HDR_VERSION, a_msg_type, a_token_len};
            res_bytes[1] = a_msg_code;
            res_bytes[2] = a_msg_id[15:8];
            res_bytes[3] = a_msg_id[7:0];
            token_left_next = a_token_len;
            written_next    = need[15:0];
          end
        end
        CMD_TOKEN: begin
          need = {1'b0, written} + 17'd1;
          if (written == '0 || token_left == '0) begin
            err_code_next = ST_INVALID;
          end else if (need > {1'b0, output_capacity}) begin
            err_code_next = ST_SMALL;
          end else begin
            res_cnt         = RES_IDX_W'(1);
            res_bytes[0]    = a_data_byte;
            token_left_next = token_left - 4'd1;
            written_next    = need[15:0];
          end
        end
        CMD_OPT_START: begin
          need = {1'b0, written} + 17'd1 + {14'd0, ext_n};
          if (written == '0 || token_left != '0 || value_left != '0 || payload_begun ||
              opts_seen >= OPT_W'(MAX_OPTIONS) || a_opt_number < prev_opt_number ||
              a_opt_length > max_option_length) begin
            err_code_next = ST_INVALID;
          end else if (need > {1'b0, output_capacity}) begin
            err_code_next = ST_SMALL;
          end else begin
            res_cnt      = RES_IDX_W'(ext_n + 3'd1);
            res_bytes[0] = {dext.nib, lext.nib};
            // delta extension first, then length extension
            for (int j = 1; j < RES_DEPTH; j++) begin
              pos = 2'(j - 1);
              q   = pos - dext.cnt;
              if (pos < dext.cnt) begin
                res_bytes[j] = (pos == 2'd0) ? dext.b0 : dext.b1;
              end else begin
                res_bytes[j] = (q == 2'd0) ? lext.b0 : lext.b1;
              end
            end
            prev_opt_number_next = a_opt_number;
            opts_seen_next       = opts_seen + OPT_W'(1);
            value_left_next      = a_opt_length;
            written_next         = need[15:0];
          end
        end
        CMD_OPT_VALUE: begin
          need = {1'b0, written} + 17'd1;
          if (written == '0 || value_left == '0) begin
            err_code_next = ST_INVALID;
          end else if (need > {1'b0, output_capacity}) begin
            err_code_next = ST_SMALL;
          end else begin
            res_cnt         = RES_IDX_W'(1);
            res_bytes[0]    = a_data_byte;
            value_left_next = value_left - 16'd1;
            written_next    = need[15:0];
          end
        end
        CMD_PAYLOAD: begin
          need = {1'b0, written} + (payload_begun ? 17'd1 : 17'd2);
          if (written == '0 || token_left != '0 || value_left != '0) begin
            err_code_next = ST_INVALID;
          end else if (need > {1'b0, output_capacity}) begin
            err_code_next = ST_SMALL;
          end else begin
            if (payload_begun) begin
              res_cnt      = RES_IDX_W'(1);
              res_bytes[0] = a_data_byte;
            end else begin
              res_cnt      = RES_IDX_W'(2);
              res_bytes[0] = PAYLOAD_MARKER;
              res_bytes[1] = a_data_byte;
            end
            payload_begun_next = 1'b1;
            written_next       = need[15:0];
          end
        end
        default: begin
          // unused command codes change nothing
        end
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      output_capacity   <= CAPACITY_RESET;
      max_option_length <= MAX_OPT_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OUTPUT_CAPACITY:   output_capacity   <= cfg_data;
        REG_MAX_OPTION_LENGTH: max_option_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // message state, updated as an item leaves the item register
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_opt_number <= '0;
      written         <= '0;
      opts_seen       <= '0;
      token_left      <= '0;
      value_left      <= '0;
      payload_begun   <= 1'b0;
      err_code        <= ST_OK;
    end else if (a_move) begin
      prev_opt_number <= prev_opt_number_next;
      written         <= written_next;
      opts_seen       <= opts_seen_next;
      token_left      <= token_left_next;
      value_left      <= value_left_next;
      payload_begun   <= payload_begun_next;
      err_code        <= err_code_next;
    end
  end

  // item register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (item_fire) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      a_command    <= command;
      a_version    <= version;
      a_msg_type   <= msg_type;
      a_token_len  <= token_len;
      a_msg_code   <= msg_code;
      a_msg_id     <= msg_id;
      a_opt_number <= opt_number;
      a_opt_length <= opt_length;
      a_data_byte  <= data_byte;
    end
  end

  // result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_idx   <= '0;
      b_cnt   <= '0;
    end else if (b_load) begin
      b_valid <= 1'b1;
      b_idx   <= '0;
      b_cnt   <= res_cnt;
    end else if (out_fire) begin
      if (b_last) begin
        b_valid <= 1'b0;
        b_idx   <= '0;
      end else begin
        b_idx <= b_idx + RES_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      for (int i = 0; i < RES_DEPTH; i++) begin
        b_bytes[i] <= res_bytes[i];
      end
      b_is_status <= res_end;
      b_status    <= res_status;
      b_count     <= res_count;
    end
  end

  // checks
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (b_idx < b_cnt))
    else $error("result index beyond buffered count");

  a_status_single: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_is_status) |-> (b_cnt == RES_IDX_W'(1)))
    else $error("status result not alone in buffer");

  a_token_bound: assert property (@(posedge clk) disable iff (rst)
    int'(token_left) <= MAX_TOKEN)
    else $error("token count above limit");

  a_opts_bound: assert property (@(posedge clk) disable iff (rst)
    int'(opts_seen) <= MAX_OPTIONS)
    else $error("option count above limit");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    b_load |=> (b_valid && b_idx == '0))
    else $error("loaded results not presented");

endmodule
